@@ sv/inv3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inv3_pkg
// Widths, constant tables and stage bundles shared by the 3x3 inverse.
// ----------------------------------------------------------------------------
package inv3_pkg;

  localparam int EW    = 32;   // element and result width
  localparam int PW    = 64;   // 2x2 product width
  localparam int CW    = 65;   // cofactor width
  localparam int DW    = 99;   // determinant width
  localparam int RW    = 100;  // divider partial remainder width
  localparam int QB    = 33;   // quotient bits produced by the divider
  localparam int LW    = 41;   // determinant limit register width
  localparam int NIN   = 9;    // elements per matrix
  localparam int NPROD = 18;   // products feeding the cofactors

  localparam logic [LW-1:0] LIMIT_RESET = 41'd281475;

  localparam logic [QB:0]   QPOS_MAX = 34'h0_7FFF_FFFF;
  localparam logic [QB:0]   QNEG_MAX = 34'h0_8000_0000;
  localparam logic [EW-1:0] INV_MAX  = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] INV_MIN  = 32'h8000_0000;

  typedef logic [3:0] idx_t;

  // Cofactor i is prod[2i] - prod[2i+1]; element index is row*3+col.
  localparam idx_t PROD_A [NPROD] = '{
    4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
    4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam idx_t PROD_B [NPROD] = '{
    4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
    4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
    logic          ovf;
    logic          neg;
  } inv3_lane_t;

  typedef struct packed {
    logic                  valid;
    logic                  sing;
    logic [DW-1:0]         dmag;
    inv3_lane_t [NIN-1:0]  lane;
  } inv3_div_t;

  typedef struct packed {
    logic                     sing;
    logic [NIN-1:0][EW-1:0]   inv;
  } inv3_res_t;

endpackage

@@ sv/inv3_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inv3_in_if
// Input channel: one 3x3 matrix per beat.
// ----------------------------------------------------------------------------
interface inv3_in_if;
  import inv3_pkg::*;

  logic valid;
  logic ready;
  logic signed [EW-1:0] m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22;

  modport source (output valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                  input ready);
  modport sink   (input valid, m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22,
                  output ready);
endinterface

@@ sv/inv3_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inv3_out_if
// Result channel: one inverse matrix and a singular flag per beat.
// ----------------------------------------------------------------------------
interface inv3_out_if;
  import inv3_pkg::*;

  logic valid;
  logic ready;
  logic signed [EW-1:0] inv_00, inv_01, inv_02, inv_10, inv_11, inv_12;
  logic signed [EW-1:0] inv_20, inv_21, inv_22;
  logic singular;

  modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, singular, input ready);
  modport sink   (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, singular, output ready);
endinterface

@@ sv/inv3_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inv3_front
// Seven stages: cofactor products, cofactors, determinant partial products,
// determinant, magnitudes, and the divider setup with the singular test.
// ----------------------------------------------------------------------------
module inv3_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [inv3_pkg::NIN-1:0][inv3_pkg::EW-1:0]   in_m,
  input  logic [inv3_pkg::LW-1:0]                      det_limit,
  output inv3_pkg::inv3_div_t                          div_out
);
  import inv3_pkg::*;

  localparam int NW = CW + 2 * FRAC_BITS;

  logic signed [EW-1:0] m_s [NIN];

  logic [5:0] vld_r, vld_nxt;

  logic signed [PW-1:0] prod_r [NPROD], prod_nxt [NPROD];
  logic signed [EW-1:0] row0_s1_r [3], row0_s2_r [3];
  logic signed [CW-1:0] adj_r [NIN], adj_nxt [NIN];
  logic signed [CW-1:0] adj3_r [NIN], adj4_r [NIN], adj5_r [NIN];
  logic signed [CW-1:0] plo_r [3], plo_nxt [3], phi_r [3], phi_nxt [3];
  logic signed [DW-1:0] dpart_r [3], dpart_nxt [3];
  logic signed [DW-1:0] det_r, det_nxt;
  logic [DW-1:0]        dmag_r, dmag_nxt;
  logic                 dneg_r, dneg_nxt;
  logic [CW-1:0]        cmag_r [NIN], cmag_nxt [NIN];
  logic                 cneg_r [NIN], cneg_nxt [NIN];
  inv3_div_t            div_r, div_nxt;

  always_comb begin
    for (int i = 0; i < NIN; i++) begin
      m_s[i] = $signed(in_m[i]);
    end
  end

  assign vld_nxt = {vld_r[4:0], in_valid};

  // Stage 1 and 2: the eighteen products and the nine cofactors.
  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      prod_nxt[k] = m_s[PROD_A[k]] * m_s[PROD_B[k]];
    end
    for (int i = 0; i < NIN; i++) begin
      adj_nxt[i] = CW'(prod_r[2*i]) - CW'(prod_r[2*i+1]);
    end
  end

  // Stage 3: row 0 times cofactors 0, 3 and 6, split into two narrow products.
  always_comb begin
    logic signed [EW:0] lo_ext;
    logic signed [EW:0] hi_part;
    for (int j = 0; j < 3; j++) begin
      lo_ext     = $signed({1'b0, adj_r[3*j][EW-1:0]});
      hi_part    = $signed(adj_r[3*j][CW-1:EW]);
      plo_nxt[j] = row0_s2_r[j] * lo_ext;
      phi_nxt[j] = row0_s2_r[j] * hi_part;
    end
  end

  // Stage 4 and 5: recombine the halves, then sum the three terms.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dpart_nxt[j] = (DW'(phi_r[j]) <<< EW) + DW'(plo_r[j]);
    end
    det_nxt = dpart_r[0] + dpart_r[1] + dpart_r[2];
  end

  // Stage 6: magnitudes and signs.
  always_comb begin
    dneg_nxt = det_r[DW-1];
    dmag_nxt = dneg_nxt ? DW'(-det_r) : DW'(det_r);
    for (int i = 0; i < NIN; i++) begin
      cneg_nxt[i] = adj5_r[i][CW-1];
      cmag_nxt[i] = cneg_nxt[i] ? CW'(-adj5_r[i]) : CW'(adj5_r[i]);
    end
  end

  // Stage 7: the numerator is the cofactor magnitude scaled by 2^(2*FRAC_BITS). Its top
  // part seeds the remainder; a seed at or above the divisor means the
  // quotient needs more than QB bits and will saturate.
  always_comb begin
    logic [NW-1:0] num;
    logic [RW-1:0] seed;
    div_nxt.valid = vld_r[5];
    div_nxt.sing  = dmag_r <= DW'(det_limit);
    div_nxt.dmag  = dmag_r;
    for (int i = 0; i < NIN; i++) begin
      num  = NW'(cmag_r[i]) << (2 * FRAC_BITS);
      seed = RW'(num >> QB);
      div_nxt.lane[i].rem = seed;
      div_nxt.lane[i].low = num[QB-1:0];
      div_nxt.lane[i].quo = '0;
      div_nxt.lane[i].ovf = seed >= RW'(dmag_r);
      div_nxt.lane[i].neg = cneg_r[i] ^ dneg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      div_r.valid <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
      div_r <= div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= prod_nxt;
      for (int j = 0; j < 3; j++) begin
        row0_s1_r[j] <= m_s[j];
      end
      row0_s2_r <= row0_s1_r;
      adj_r     <= adj_nxt;
      adj3_r    <= adj_r;
      adj4_r    <= adj3_r;
      adj5_r    <= adj4_r;
      plo_r     <= plo_nxt;
      phi_r     <= phi_nxt;
      dpart_r   <= dpart_nxt;
      det_r     <= det_nxt;
      dmag_r    <= dmag_nxt;
      dneg_r    <= dneg_nxt;
      cmag_r    <= cmag_nxt;
      cneg_r    <= cneg_nxt;
    end
  end

  assign div_out = div_r;

endmodule

@@ sv/inv3_div_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inv3_div_stage
// One restoring division step for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module inv3_div_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  inv3_pkg::inv3_div_t  d_in,
  output inv3_pkg::inv3_div_t  d_out
);
  import inv3_pkg::*;

  inv3_div_t d_r, d_nxt;

  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    d_nxt = d_in;
    for (int i = 0; i < NIN; i++) begin
      trial = {d_in.lane[i].rem[RW-2:0], d_in.lane[i].low[QB-1]};
      ge    = trial >= RW'(d_in.dmag);
      d_nxt.lane[i].rem = ge ? trial - RW'(d_in.dmag) : trial;
      d_nxt.lane[i].quo = {d_in.lane[i].quo[QB-2:0], ge};
      d_nxt.lane[i].low = {d_in.lane[i].low[QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

  // Without overflow the partial remainder always stays below the divisor; the check covers lane 0.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_r.valid && !d_r.lane[0].ovf |-> d_r.lane[0].rem < RW'(d_r.dmag))
    else $error("partial remainder not below divisor");

endmodule

@@ sv/inv3_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inv3_out
// Rounding, saturation and singular zeroing, then a two-entry skid buffer.
// ----------------------------------------------------------------------------
module inv3_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  inv3_pkg::inv3_div_t  d_in,
  input  logic                 out_ready,
  output logic                 pipe_en,
  output logic                 out_valid,
  output inv3_pkg::inv3_res_t  out_res
);
  import inv3_pkg::*;

  inv3_res_t res;
  logic      out_vld_r, out_vld_nxt, spare_vld_r, spare_vld_nxt;
  inv3_res_t out_dat_r, out_dat_nxt, spare_dat_r, spare_dat_nxt;
  logic      push, pop;

  // Round half away from zero: add one when twice the remainder reaches the
  // divisor, then clamp to the signed 32-bit range.
  always_comb begin
    logic [QB:0] rq;
    logic        rb;
    logic        sat;
    res.sing = d_in.sing;
    for (int i = 0; i < NIN; i++) begin
      sat = 1'b0;
      rb = (d_in.lane[i].rem << 1) >= RW'(d_in.dmag);
      rq = {1'b0, d_in.lane[i].quo} + (QB+1)'(rb);
      if (d_in.sing) begin
        res.inv[i] = '0;
      end else if (d_in.lane[i].neg) begin
        sat = d_in.lane[i].ovf || (rq > QNEG_MAX);
        res.inv[i] = sat ? INV_MIN : EW'(-rq);
      end else begin
        sat = d_in.lane[i].ovf || (rq > QPOS_MAX);
        res.inv[i] = sat ? INV_MAX : rq[EW-1:0];
      end
    end
  end

  assign pipe_en = !spare_vld_r;
  assign push    = pipe_en && d_in.valid;
  assign pop     = out_vld_r && out_ready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_dat_nxt   = out_dat_r;
    spare_vld_nxt = spare_vld_r;
    spare_dat_nxt = spare_dat_r;
    if (!out_vld_r || pop) begin
      if (spare_vld_r) begin
        out_vld_nxt   = 1'b1;
        out_dat_nxt   = spare_dat_r;
        spare_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = push;
        out_dat_nxt = res;
      end
    end else if (push) begin
      spare_vld_nxt = 1'b1;
      spare_dat_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r   <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      out_vld_r   <= out_vld_nxt;
      spare_vld_r <= spare_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r   <= out_dat_nxt;
    spare_dat_r <= spare_dat_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_dat_r;

  a_spare_order: assert property (@(posedge clk) disable iff (!rst_n)
    spare_vld_r |-> out_vld_r)
    else $error("skid entry held while output register empty");

  a_spare_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(spare_vld_r) |-> $past(out_vld_r && !out_ready))
    else $error("skid entry filled without a stalled output");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dat_r.sing |-> out_dat_r.inv == '0)
    else $error("singular beat carries nonzero elements");

endmodule

@@ sv/invert_3x3_matrix_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// invert_3x3_matrix_top
// 3x3 matrix inverse by the adjugate in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one matrix per beat (nine signed elements, FRAC_BITS
//   fraction bits); out_ch returns the inverse in the same format plus a
//   singular flag. A matrix whose determinant magnitude is at or below the
//   cfg_wdata value last written with cfg_we (units 2^-(3*FRAC_BITS)) comes
//   back as all zeros with singular set.
//   There are 41 register stages and the accepting edge loads the first
//   one: seven stages for the cofactor products, cofactors, determinant
//   and setup, 33 restoring division steps (one quotient bit per stage for
//   all nine elements), and the rounding stage that loads the output
//   register. Throughput is one matrix per cycle while in_ch.ready stays
//   high.
//   When the receiver stalls, one more result lands in a skid register and
//   in_ch.ready then drops; the pipeline freezes without losing a beat and
//   resumes when out_ch.ready returns.
//   Synchronous reset empties the pipeline and the output and restores the
//   determinant limit to its default.
// ----------------------------------------------------------------------------
module invert_3x3_matrix_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  inv3_in_if.sink                        in_ch,
  inv3_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [inv3_pkg::LW-1:0]        cfg_wdata
);
  import inv3_pkg::*;

  logic [LW-1:0]            det_limit_r, det_limit_nxt;
  logic                     pipe_en;
  logic [NIN-1:0][EW-1:0]   m_vec;
  inv3_div_t                chain [QB+1];
  inv3_res_t                res;

  assign det_limit_nxt = cfg_we ? cfg_wdata : det_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_limit_r <= LIMIT_RESET;
    end else begin
      det_limit_r <= det_limit_nxt;
    end
  end

  assign m_vec = {in_ch.m_22, in_ch.m_21, in_ch.m_20, in_ch.m_12, in_ch.m_11,
                  in_ch.m_10, in_ch.m_02, in_ch.m_01, in_ch.m_00};

  assign in_ch.ready = pipe_en;

  inv3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_ch.valid),
    .in_m      (m_vec),
    .det_limit (det_limit_r),
    .div_out   (chain[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_div
    inv3_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (pipe_en),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  inv3_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_in      (chain[QB]),
    .out_ready (out_ch.ready),
    .pipe_en   (pipe_en),
    .out_valid (out_ch.valid),
    .out_res   (res)
  );

  assign out_ch.inv_00   = res.inv[0];
  assign out_ch.inv_01   = res.inv[1];
  assign out_ch.inv_02   = res.inv[2];
  assign out_ch.inv_10   = res.inv[3];
  assign out_ch.inv_11   = res.inv[4];
  assign out_ch.inv_12   = res.inv[5];
  assign out_ch.inv_20   = res.inv[6];
  assign out_ch.inv_21   = res.inv[7];
  assign out_ch.inv_22   = res.inv[8];
  assign out_ch.singular = res.sing;

endmodule
